// ===== hdl/gsn_pkg.sv =====
// shared constants, codes, command and status types of the gaussian similarity normalizer
`timescale 1ns / 1ps
`default_nettype none

package gsn_pkg;

    localparam int MAX_POINTS = 64;
    localparam int MAX_DIMS   = 16;
    localparam int PT_W       = $clog2(MAX_POINTS);
    localparam int DIM_W      = $clog2(MAX_DIMS);
    localparam int ADDR_W     = PT_W + DIM_W;
    localparam int NP_W       = 7;
    localparam int ND_W       = 5;
    localparam int COORD_W    = 16;
    localparam int SQD_W      = 32;
    localparam int SUM_W      = 36;
    localparam int Y_W        = 52;
    localparam int N_W        = Y_W - 32;
    localparam int T_W        = 30;
    localparam int ACC_W      = 31;
    localparam int RCP_W      = 33;
    localparam int SIM_W      = 17;
    localparam int DEG_W      = 32;
    localparam int RT_W       = 64;
    localparam int DVN_W      = 38;
    localparam int DVR_W      = 33;
    localparam int VAL_W      = 32;
    localparam int TDATA_W    = 40;
    localparam int CNT_W      = 6;

    localparam int SQ_STEPS   = 32;
    localparam int DIV_STEPS  = 38;
    localparam int DRAIN_CYC  = 3;
    localparam int HORNER_TOP = 6;

    localparam logic [16:0]      LOG2E_Q16 = 17'd94548;
    localparam logic [29:0]      LN2_Q30   = 30'd744261118;
    localparam logic [ACC_W-1:0] ONE_Q30   = ACC_W'(1) << 30;
    localparam logic [5:0]       EXP_SHIFT = 6'd14;
    localparam logic [N_W-1:0]   N_LIMIT   = N_W'(40);

    typedef enum logic [1:0] {
        FUNC_LOAD    = 2'd0,
        FUNC_COMPUTE = 2'd1,
        FUNC_READ    = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        GOAL_SIM  = 2'd0,
        GOAL_DEG  = 2'd1,
        GOAL_NORM = 2'd2,
        GOAL_NONE = 2'd3
    } goal_t;

    typedef enum logic [1:0] {
        CFG_GOAL   = 2'd0,
        CFG_POINTS = 2'd1,
        CFG_DIMS   = 2'd2,
        CFG_SPARE  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic              item_load;
        logic              coord_we;
        logic              rd_en;
        logic [PT_W-1:0]   rd_p;
        logic [PT_W-1:0]   rd_q;
        logic [DIM_W-1:0]  rd_dim;
        logic              acc_clr;
        logic              exp_y;
        logic              exp_t;
        logic              exp_mul;
        logic              exp_div;
        logic              exp_upd;
        logic [2:0]        exp_k;
        logic              sim_fin;
        logic              sim_zero;
        logic              deg_clr;
        logic              deg_add;
        logic              deg_we;
        logic              deg_rd;
        logic [PT_W-1:0]   deg_addr;
        logic              cap_di;
        logic              cap_dj;
        logic              sq_init;
        logic              sq_step;
        logic              dv_init;
        logic              dv_step;
        logic              set_computed;
        logic              out_load;
    } gsn_cmd_t;

    typedef struct packed {
        func_t            func;
        logic [PT_W-1:0]  row;
        logic [PT_W-1:0]  col;
        logic             flag_any;
        logic             deg_nonzero;
        logic             out_busy;
    } gsn_status_t;

    function automatic logic [RCP_W-1:0] recip(input logic [2:0] k);
        logic [RCP_W-1:0] r;
        case (k)
            3'd1:    r = RCP_W'(64'd4294967296);
            3'd2:    r = RCP_W'(64'd2147483648);
            3'd3:    r = RCP_W'(64'd1431655765);
            3'd4:    r = RCP_W'(64'd1073741824);
            3'd5:    r = RCP_W'(64'd858993459);
            3'd6:    r = RCP_W'(64'd715827882);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/gsn_datapath.sv =====
// datapath: coordinate and degree memories, distance, exp, square root, divider, result register
`timescale 1ns / 1ps
`default_nettype none

module gsn_datapath import gsn_pkg::*; (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire gsn_cmd_t            cmd,
    output gsn_status_t              status,
    input  wire logic [TDATA_W-1:0]  s_tdata,
    input  wire logic [1:0]          s_tuser,
    input  wire logic [NP_W-1:0]     num_points,
    input  wire goal_t               goal,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [TDATA_W-1:0]       m_tdata
);

    logic [COORD_W-1:0] coord_mem [MAX_POINTS*MAX_DIMS];
    logic [DEG_W-1:0]   deg_mem [MAX_POINTS];

    func_t               func_reg;
    logic [PT_W-1:0]     pidx_reg, row_reg, col_reg;
    logic [DIM_W-1:0]    didx_reg;
    logic [COORD_W-1:0]  coord_reg;
    logic                nr_reg, bi_reg, computed_reg;

    logic [COORD_W-1:0]  ca_reg, cb_reg;
    logic                v1_reg, v2_reg;
    logic [SQD_W-1:0]    sqd_reg;
    logic [SUM_W-1:0]    dsum_reg;
    logic [Y_W-1:0]      y_reg;
    logic [N_W-1:0]      n_reg;
    logic [T_W-1:0]      t_reg;
    logic [ACC_W-1:0]    eacc_reg;
    logic [60:0]         eprod_reg;
    logic [T_W-1:0]      ev_reg, q0_reg;
    logic [SIM_W-1:0]    sim_reg;
    logic [DEG_W-1:0]    dsumdeg_reg, drd_reg, di_reg, dj_reg;
    logic [RT_W-1:0]     rrem_reg, rres_reg, rbit_reg;
    logic [DVN_W-1:0]    dq_reg;
    logic [DVR_W-1:0]    drem_reg;
    logic                out_valid_reg;
    logic [VAL_W-1:0]    oval_reg;
    logic                ozd_reg, onr_reg, obi_reg;

    logic signed [COORD_W:0] diff;
    logic [COORD_W:0]        mag;
    logic [63:0]             dprod;
    logic [RT_W-1:0]         rtrial;
    logic [DVR_W-1:0]        dshift;
    logic [T_W-1:0]          rem_k, q_fix;
    logic [VAL_W-1:0]        val_next;
    logic                    zd_next;
    logic [5:0]              shamt;
    logic [ACC_W-1:0]        sim_full;

    // item latch and flags
    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            func_reg  <= func_t'(s_tuser);
            pidx_reg  <= s_tdata[5:0];
            didx_reg  <= s_tdata[9:6];
            coord_reg <= s_tdata[25:10];
            row_reg   <= s_tdata[31:26];
            col_reg   <= s_tdata[37:32];
            nr_reg    <= ~computed_reg;
            bi_reg    <= ({1'b0, s_tdata[31:26]} >= num_points) ||
                         ({1'b0, s_tdata[37:32]} >= num_points);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            computed_reg <= 1'b0;
        end
        else if (cmd.set_computed)
        begin
            computed_reg <= 1'b1;
        end
    end

    // coordinate memory, two registered read ports
    always_ff @(posedge clk)
    begin
        if (cmd.coord_we)
        begin
            coord_mem[{pidx_reg, didx_reg}] <= coord_reg;
        end
        if (cmd.rd_en)
        begin
            ca_reg <= coord_mem[{cmd.rd_p, cmd.rd_dim}];
            cb_reg <= coord_mem[{cmd.rd_q, cmd.rd_dim}];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.rd_en;
            v2_reg <= v1_reg;
        end
    end

    // squared distance
    always_comb
    begin
        diff = $signed({ca_reg[COORD_W-1], ca_reg}) - $signed({cb_reg[COORD_W-1], cb_reg});
        mag  = diff[COORD_W] ? (COORD_W+1)'(-diff) : diff;
    end

    always_ff @(posedge clk)
    begin
        sqd_reg <= SQD_W'(mag[COORD_W-1:0]) * SQD_W'(mag[COORD_W-1:0]);
        if (cmd.acc_clr)
        begin
            dsum_reg <= '0;
        end
        else if (v2_reg)
        begin
            dsum_reg <= dsum_reg + SUM_W'(sqd_reg);
        end
    end

    // exp(-x) pipeline
    always_comb
    begin
        rem_k    = ev_reg - T_W'(q0_reg * T_W'(cmd.exp_k));
        q_fix    = (rem_k >= T_W'(cmd.exp_k)) ? q0_reg + T_W'(1) : q0_reg;
        shamt    = n_reg[5:0] + EXP_SHIFT;
        sim_full = eacc_reg >> shamt;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exp_y)
        begin
            y_reg <= Y_W'(dsum_reg[SUM_W-1:1]) * Y_W'(LOG2E_Q16);
        end
        if (cmd.exp_t)
        begin
            n_reg    <= y_reg[Y_W-1:32];
            t_reg    <= T_W'((46'(y_reg[31:16]) * 46'(LN2_Q30)) >> 16);
            eacc_reg <= ONE_Q30;
        end
        if (cmd.exp_mul)
        begin
            eprod_reg <= 61'(t_reg) * 61'(eacc_reg);
        end
        if (cmd.exp_div)
        begin
            ev_reg <= eprod_reg[59:30];
            q0_reg <= T_W'((63'(eprod_reg[59:30]) * 63'(recip(cmd.exp_k))) >> 32);
        end
        if (cmd.exp_upd)
        begin
            eacc_reg <= ONE_Q30 - ACC_W'(q_fix);
        end
        if (cmd.sim_zero)
        begin
            sim_reg <= '0;
        end
        else if (cmd.sim_fin)
        begin
            sim_reg <= (n_reg > N_LIMIT) ? '0 : sim_full[SIM_W-1:0];
        end
    end

    // degree memory and row sum
    always_ff @(posedge clk)
    begin
        if (cmd.deg_clr)
        begin
            dsumdeg_reg <= '0;
        end
        else if (cmd.deg_add)
        begin
            dsumdeg_reg <= dsumdeg_reg + DEG_W'(sim_reg);
        end
        if (cmd.deg_we)
        begin
            deg_mem[cmd.deg_addr] <= dsumdeg_reg;
        end
        if (cmd.deg_rd)
        begin
            drd_reg <= deg_mem[cmd.deg_addr];
        end
        if (cmd.cap_di)
        begin
            di_reg <= drd_reg;
        end
        if (cmd.cap_dj)
        begin
            dj_reg <= drd_reg;
        end
    end

    // bitwise square root and restoring divider
    always_comb
    begin
        dprod  = 64'(di_reg) * 64'(dj_reg);
        rtrial = rres_reg + rbit_reg;
        dshift = {drem_reg[DVR_W-2:0], dq_reg[DVN_W-1]};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sq_init)
        begin
            rrem_reg <= {dprod[RT_W-11:0], 10'b0};
            rres_reg <= '0;
            rbit_reg <= RT_W'(1) << 62;
        end
        else if (cmd.sq_step)
        begin
            if (rrem_reg >= rtrial)
            begin
                rrem_reg <= rrem_reg - rtrial;
                rres_reg <= (rres_reg >> 1) + rbit_reg;
            end
            else
            begin
                rres_reg <= rres_reg >> 1;
            end
            rbit_reg <= rbit_reg >> 2;
        end
        if (cmd.dv_init)
        begin
            dq_reg   <= {sim_reg, 21'b0};
            drem_reg <= '0;
        end
        else if (cmd.dv_step)
        begin
            if (dshift >= {1'b0, rres_reg[31:0]})
            begin
                drem_reg <= dshift - {1'b0, rres_reg[31:0]};
                dq_reg   <= {dq_reg[DVN_W-2:0], 1'b1};
            end
            else
            begin
                drem_reg <= dshift;
                dq_reg   <= {dq_reg[DVN_W-2:0], 1'b0};
            end
        end
    end

    // result select
    always_comb
    begin
        val_next = '0;
        zd_next  = 1'b0;
        if (!(nr_reg || bi_reg))
        begin
            unique case (goal)
                GOAL_SIM:
                begin
                    val_next = VAL_W'(sim_reg);
                end
                GOAL_DEG:
                begin
                    val_next = (row_reg == col_reg) ? di_reg : '0;
                end
                GOAL_NORM:
                begin
                    if (di_reg == '0 || dj_reg == '0)
                    begin
                        zd_next = 1'b1;
                    end
                    else
                    begin
                        val_next = (dq_reg[DVN_W-1:VAL_W] != '0) ? '1 : dq_reg[VAL_W-1:0];
                    end
                end
                default:
                begin
                    val_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            oval_reg <= val_next;
            ozd_reg  <= zd_next;
            onr_reg  <= nr_reg;
            obi_reg  <= bi_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, obi_reg, onr_reg, ozd_reg, oval_reg};

    assign status.func        = func_reg;
    assign status.row         = row_reg;
    assign status.col         = col_reg;
    assign status.flag_any    = nr_reg | bi_reg;
    assign status.deg_nonzero = (di_reg != '0) && (dj_reg != '0);
    assign status.out_busy    = out_valid_reg & ~m_tready;

endmodule

`default_nettype wire

// ===== hdl/gsn_ctrl.sv =====
// controller: sequencing of loads, degree computation and entry reads
`timescale 1ns / 1ps
`default_nettype none

module gsn_ctrl import gsn_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [NP_W-1:0]   num_points,
    input  wire logic [ND_W-1:0]   num_dims,
    input  wire goal_t             goal,
    input  wire gsn_status_t       status,
    output gsn_cmd_t               cmd
);

    typedef enum logic [22:0] {
        ST_IDLE    = 23'h1 << 0,
        ST_DECODE  = 23'h1 << 1,
        ST_C_ROW   = 23'h1 << 2,
        ST_C_PAIR  = 23'h1 << 3,
        ST_DIST    = 23'h1 << 4,
        ST_DRAIN   = 23'h1 << 5,
        ST_EXP_Y   = 23'h1 << 6,
        ST_EXP_T   = 23'h1 << 7,
        ST_EXP_A   = 23'h1 << 8,
        ST_EXP_B   = 23'h1 << 9,
        ST_EXP_C   = 23'h1 << 10,
        ST_EXP_F   = 23'h1 << 11,
        ST_C_ADD   = 23'h1 << 12,
        ST_C_WRITE = 23'h1 << 13,
        ST_RD_DI   = 23'h1 << 14,
        ST_RD_DJ   = 23'h1 << 15,
        ST_RD_W    = 23'h1 << 16,
        ST_CHK     = 23'h1 << 17,
        ST_SQ_INIT = 23'h1 << 18,
        ST_SQ      = 23'h1 << 19,
        ST_DV_INIT = 23'h1 << 20,
        ST_DV      = 23'h1 << 21,
        ST_FINISH  = 23'h1 << 22
    } state_t;

    state_t            state_reg, state_next;
    logic [NP_W-1:0]   pi_reg, pi_next, qi_reg, qi_next;
    logic [ND_W-1:0]   dim_reg, dim_next;
    logic [2:0]        k_reg, k_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              cmpt_reg, cmpt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pi_reg    <= '0;
            qi_reg    <= '0;
            dim_reg   <= '0;
            k_reg     <= '0;
            cnt_reg   <= '0;
            cmpt_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pi_reg    <= pi_next;
            qi_reg    <= qi_next;
            dim_reg   <= dim_next;
            k_reg     <= k_next;
            cnt_reg   <= cnt_next;
            cmpt_reg  <= cmpt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pi_next    = pi_reg;
        qi_next    = qi_reg;
        dim_next   = dim_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        cmpt_next  = cmpt_reg;
        cmd        = '0;
        cmd.rd_p   = pi_reg[PT_W-1:0];
        cmd.rd_q   = qi_reg[PT_W-1:0];
        cmd.rd_dim = dim_reg[DIM_W-1:0];
        cmd.exp_k  = k_reg;
        cmd.deg_addr = pi_reg[PT_W-1:0];
        in_ready   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.item_load = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (status.func)
                    FUNC_LOAD:
                    begin
                        cmd.coord_we = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    FUNC_COMPUTE:
                    begin
                        cmpt_next  = 1'b1;
                        pi_next    = '0;
                        state_next = ST_C_ROW;
                    end
                    FUNC_READ:
                    begin
                        cmpt_next = 1'b0;
                        pi_next   = NP_W'(status.row);
                        qi_next   = NP_W'(status.col);
                        dim_next  = '0;
                        if (status.flag_any)
                        begin
                            state_next = ST_FINISH;
                        end
                        else if (status.row == status.col)
                        begin
                            cmd.sim_zero = 1'b1;
                            state_next   = ST_RD_DI;
                        end
                        else
                        begin
                            state_next = ST_DIST;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_C_ROW:
            begin
                cmd.deg_clr = 1'b1;
                qi_next     = '0;
                state_next  = ST_C_PAIR;
            end
            ST_C_PAIR:
            begin
                if (pi_reg >= num_points || qi_reg >= num_points)
                begin
                    state_next = ST_C_WRITE;
                end
                else if (qi_reg == pi_reg)
                begin
                    qi_next = qi_reg + NP_W'(1);
                end
                else
                begin
                    dim_next   = '0;
                    state_next = ST_DIST;
                end
            end
            ST_DIST:
            begin
                cmd.rd_en   = 1'b1;
                cmd.acc_clr = (dim_reg == '0);
                if (dim_reg == num_dims - ND_W'(1))
                begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    dim_next = dim_reg + ND_W'(1);
                end
            end
            ST_DRAIN:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DRAIN_CYC - 1))
                begin
                    state_next = ST_EXP_Y;
                end
            end
            ST_EXP_Y:
            begin
                cmd.exp_y  = 1'b1;
                state_next = ST_EXP_T;
            end
            ST_EXP_T:
            begin
                cmd.exp_t  = 1'b1;
                k_next     = 3'(HORNER_TOP);
                state_next = ST_EXP_A;
            end
            ST_EXP_A:
            begin
                cmd.exp_mul = 1'b1;
                state_next  = ST_EXP_B;
            end
            ST_EXP_B:
            begin
                cmd.exp_div = 1'b1;
                state_next  = ST_EXP_C;
            end
            ST_EXP_C:
            begin
                cmd.exp_upd = 1'b1;
                if (k_reg == 3'd1)
                begin
                    state_next = ST_EXP_F;
                end
                else
                begin
                    k_next     = k_reg - 3'd1;
                    state_next = ST_EXP_A;
                end
            end
            ST_EXP_F:
            begin
                cmd.sim_fin = 1'b1;
                state_next  = cmpt_reg ? ST_C_ADD : ST_RD_DI;
            end
            ST_C_ADD:
            begin
                cmd.deg_add = 1'b1;
                qi_next     = qi_reg + NP_W'(1);
                state_next  = ST_C_PAIR;
            end
            ST_C_WRITE:
            begin
                cmd.deg_we = 1'b1;
                if (pi_reg == NP_W'(MAX_POINTS - 1))
                begin
                    cmd.set_computed = 1'b1;
                    state_next       = ST_IDLE;
                end
                else
                begin
                    pi_next    = pi_reg + NP_W'(1);
                    state_next = ST_C_ROW;
                end
            end
            ST_RD_DI:
            begin
                cmd.deg_rd = 1'b1;
                state_next = ST_RD_DJ;
            end
            ST_RD_DJ:
            begin
                cmd.cap_di   = 1'b1;
                cmd.deg_rd   = 1'b1;
                cmd.deg_addr = qi_reg[PT_W-1:0];
                state_next   = ST_RD_W;
            end
            ST_RD_W:
            begin
                cmd.cap_dj = 1'b1;
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (goal == GOAL_NORM && status.deg_nonzero)
                begin
                    state_next = ST_SQ_INIT;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SQ_INIT:
            begin
                cmd.sq_init = 1'b1;
                cnt_next    = '0;
                state_next  = ST_SQ;
            end
            ST_SQ:
            begin
                cmd.sq_step = 1'b1;
                cnt_next    = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(SQ_STEPS - 1))
                begin
                    state_next = ST_DV_INIT;
                end
            end
            ST_DV_INIT:
            begin
                cmd.dv_init = 1'b1;
                cnt_next    = '0;
                state_next  = ST_DV;
            end
            ST_DV:
            begin
                cmd.dv_step = 1'b1;
                cnt_next    = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/gaussian_similarity_normalizer.sv =====
// top level: configuration registers, controller and datapath
//
//  channel   dir  signals                      content
//  s_*       in   s_tvalid s_tready s_tdata    command beat, func in s_tuser
//  m_*       out  m_tvalid m_tready m_tdata    read result beat
//  cfg_*     in   cfg_we cfg_index cfg_data    register write, no wait
//
//  a read on the diagonal skips the distance and exp steps and a flagged read
//  goes straight to its result; the normalized goal adds a bitwise square root
//  and restoring divider, one bit a cycle. compute walks every pair of distinct
//  points in use and clears and writes each row beyond num_points, over all 64 rows.
//  reset clears state only; no clearing pass. a held result beat stalls
//  only the next read, in its last state.
`timescale 1ns / 1ps
`default_nettype none

module gaussian_similarity_normalizer import gsn_pkg::*; (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [TDATA_W-1:0]  s_tdata,   // point_index, dim_index, coord_value, row, col
    input  wire logic [1:0]          s_tuser,   // func
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [TDATA_W-1:0]       m_tdata,   // entry_value, zero_degree, not_ready, bad_index
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [NP_W-1:0]     cfg_data
);

    goal_t            goal_reg;
    logic [NP_W-1:0]  np_reg, np_eff;
    logic [ND_W-1:0]  nd_reg, nd_eff;
    gsn_cmd_t         cmd;
    gsn_status_t      status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_reg <= GOAL_SIM;
            np_reg   <= NP_W'(1);
            nd_reg   <= ND_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_GOAL:   goal_reg <= goal_t'(cfg_data[1:0]);
                CFG_POINTS: np_reg   <= cfg_data;
                CFG_DIMS:   nd_reg   <= cfg_data[ND_W-1:0];
                default:    goal_reg <= goal_reg;
            endcase
        end
    end

    assign np_eff = (np_reg == '0) ? NP_W'(1) :
                    (np_reg > NP_W'(MAX_POINTS)) ? NP_W'(MAX_POINTS) : np_reg;
    assign nd_eff = (nd_reg == '0) ? ND_W'(1) :
                    (nd_reg > ND_W'(MAX_DIMS)) ? ND_W'(MAX_DIMS) : nd_reg;

    gsn_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .num_points (np_eff),
        .num_dims   (nd_eff),
        .goal       (goal_reg),
        .status     (status),
        .cmd        (cmd)
    );

    gsn_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .num_points (np_eff),
        .goal       (goal_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

`ifndef SYNTHESIS
    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken twice in a row");

    a_flagged_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[33] || m_tdata[34]) |-> m_tdata[32:0] == '0)
        else $error("flagged read carries a value");

    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result loaded while idle");
`endif

endmodule

`default_nettype wire
